// ===== sv/ogs_pkg.sv =====
// ----------------------------------------------------------------------------
// ogs_pkg
// Shared types, codes, constants and sigmoid tables of the occupancy grid
// store.
// ----------------------------------------------------------------------------
package ogs_pkg;

    // Field widths
    localparam int COORD_W    = 16;
    localparam int LOGODDS_W  = 16;
    localparam int PROB_W     = 17;
    localparam int CMD_W      = 2;
    localparam int WORD_W     = PROB_W + 1;   // {known, probability}

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BINARY = 2'd3;

    localparam logic [3:0] RST_HALF_X = 4'd15;
    localparam logic [3:0] RST_HALF_Y = 4'd15;
    localparam logic [2:0] RST_HALF_Z = 3'd7;
    localparam logic       RST_BINARY = 1'b0;

    // Default grid capacity
    localparam int DEF_MAX_HALF_X = 15;
    localparam int DEF_MAX_HALF_Y = 15;
    localparam int DEF_MAX_HALF_Z = 7;

    // Probability codes
    localparam logic [PROB_W-1:0] PROB_ONE  = 17'd65536;
    localparam logic [PROB_W-1:0] PROB_HALF = 17'd32768;
    localparam logic [PROB_W-1:0] PROB_ZERO = 17'd0;

    // Sigmoid arithmetic: |L| below this has a nonzero tail
    localparam logic [LOGODDS_W-1:0] SIG_LIMIT = 16'd3072;

    localparam int Q20_FRAC   = 20;
    localparam int EN_W       = 36;          // e^n in Q20, n = 0..11
    localparam int EN_HALF    = 18;
    localparam int EF_W       = 22;          // e^(f/256) in Q20
    localparam int PP_W       = EN_HALF + EF_W;
    localparam int PROD_W     = EN_W + EF_W;
    localparam int D_W        = PROD_W - Q20_FRAC;
    localparam int Q_W        = 16;
    localparam int DSH_W      = D_W + Q_W - 1;
    localparam int QCNT_W     = $clog2(Q_W);
    localparam int EN_ENTRIES = 16;
    localparam int EF_ENTRIES = 256;

    localparam longint unsigned Q20_ONE_L = 64'd1048576;
    localparam longint unsigned Q20_E_L   = 64'd2850325;

    localparam logic [PROD_W-1:0] PROD_ROUND = PROD_W'(64'd524288);
    localparam logic [D_W-1:0]    D_ONE      = D_W'(64'd1048576);
    localparam logic [D_W-1:0]    DIV_NUM    = D_W'(64'd1 << 36);

    // Rounded-up reciprocals of the Taylor divisors k = 1..12 in Q32; a
    // dividend below 2^20 times one of these, shifted down 32, gives the
    // truncated quotient
    localparam longint unsigned TAYLOR_RECIP [12] = '{
        64'd4294967296, 64'd2147483648, 64'd1431655766, 64'd1073741824,
        64'd858993460,  64'd715827883,  64'd613566757,  64'd536870912,
        64'd477218589,  64'd429496730,  64'd390451573,  64'd357913942
    };

    // Commands
    typedef enum logic [CMD_W-1:0] {
        CMD_GET   = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_LOAD  = 2'd3
    } t_command;

    // Controller states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_SUM,
        S_DINIT,
        S_DIV,
        S_READ,
        S_WRITE
    } t_state;

    // Configuration registers
    typedef struct packed {
        logic [3:0] half_extent_x;
        logic [3:0] half_extent_y;
        logic [2:0] half_extent_z;
        logic       binary_mode;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic clr_en;
        logic accept;
        logic mul_lo;
        logic mul_hi;
        logic sum;
        logic div_init;
        logic div_step;
        logic rd_en;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic sig_need;
        logic div_last;
    } t_dp_stat;

    typedef logic [EN_W-1:0] t_en_table [EN_ENTRIES];
    typedef logic [EF_W-1:0] t_ef_table [EF_ENTRIES];

    // e^n in Q20, built by repeated rounded multiplication by e
    function automatic t_en_table build_en_table();
        t_en_table       tbl;
        longint unsigned en;
        en = Q20_ONE_L;
        for (int n = 0; n < EN_ENTRIES; n++) begin
            tbl[n] = EN_W'(en);
            en = (en * Q20_E_L + (Q20_ONE_L >> 1)) >> Q20_FRAC;
        end
        return tbl;
    endfunction

    // e^(f/256) in Q20, twelve truncated Taylor terms
    function automatic t_ef_table build_ef_table();
        t_ef_table       tbl;
        longint unsigned t;
        longint unsigned ef;
        for (int f = 0; f < EF_ENTRIES; f++) begin
            t  = Q20_ONE_L;
            ef = Q20_ONE_L;
            for (int k = 1; k <= 12; k++) begin
                // scale by f/(256*k): drop 8 bits, then multiply by 1/k
                t  = (((t * 64'(f)) >> 8) * TAYLOR_RECIP[k - 1]) >> 32;
                ef = ef + t;
            end
            tbl[f] = EF_W'(ef);
        end
        return tbl;
    endfunction

    localparam t_en_table EN_TABLE = build_en_table();
    localparam t_ef_table EF_TABLE = build_ef_table();

endpackage

// ===== sv/ogs_ram.sv =====
// ----------------------------------------------------------------------------
// ogs_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ogs_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 14415
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, hold when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ogs_ctrl.sv =====
// ----------------------------------------------------------------------------
// ogs_ctrl
// Controller: clearing sweep after reset, item acceptance, sigmoid
// sequencing, read-modify-write of one cell and the output valid flag.
// ----------------------------------------------------------------------------
module ogs_ctrl import ogs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    out_free;
    logic    ready;
    t_dp_cmd cmd;

    // State and output flag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        ready   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ready = 1'b1;
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = i_stat.sig_need ? S_MUL_LO : S_READ;
                end
            end
            S_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                n_state    = S_MUL_HI;
            end
            S_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                cmd.sum = 1'b1;
                n_state = S_DINIT;
            end
            S_DINIT: begin
                cmd.div_init = 1'b1;
                n_state      = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                cmd.rd_en = 1'b1;
                n_state   = S_WRITE;
            end
            S_WRITE: begin
                // finish only when the output register is free; take the
                // next item in the same cycle
                if (out_free) begin
                    cmd.finish = 1'b1;
                    ready      = 1'b1;
                    if (i_in_valid) begin
                        cmd.accept = 1'b1;
                        n_state    = i_stat.sig_need ? S_MUL_LO : S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid: set on finish, drop when taken
    always_comb begin
        if (cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_ready  = ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // No item is taken during the clearing sweep
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("item accepted during clearing sweep");

    // A result never overwrites one that is still waiting
    a_finish_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote a pending result");

    // A new result only comes out of the write step
    a_valid_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_WRITE))
        else $error("output valid rose outside the write step");

endmodule

// ===== sv/ogs_dp.sv =====
// ----------------------------------------------------------------------------
// ogs_dp
// Datapath: range check and cell index, sigmoid multiply and divide, cell
// update, known-cell count and the output register.
// ----------------------------------------------------------------------------
module ogs_dp import ogs_pkg::*; #(
    parameter int MAX_HALF_X = DEF_MAX_HALF_X,
    parameter int MAX_HALF_Y = DEF_MAX_HALF_Y,
    parameter int MAX_HALF_Z = DEF_MAX_HALF_Z,
    localparam int DEPTH = (2 * MAX_HALF_X + 1) * (2 * MAX_HALF_Y + 1)
                         * (2 * MAX_HALF_Z + 1),
    localparam int AW    = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cfg                        i_cfg,
    input  t_dp_cmd                     i_cmd,
    output t_dp_stat                    o_stat,
    input  logic [CMD_W-1:0]            i_command,
    input  logic signed [COORD_W-1:0]   i_coord_x,
    input  logic signed [COORD_W-1:0]   i_coord_y,
    input  logic signed [COORD_W-1:0]   i_coord_z,
    input  logic [PROB_W-1:0]           i_prob_value,
    input  logic signed [LOGODDS_W-1:0] i_log_odds,
    output logic                        o_ram_we,
    output logic [AW-1:0]               o_ram_waddr,
    output logic [WORD_W-1:0]           o_ram_wdata,
    output logic                        o_ram_re,
    output logic [AW-1:0]               o_ram_raddr,
    input  logic [WORD_W-1:0]           i_ram_rdata,
    output logic [PROB_W-1:0]           o_probability,
    output logic                        o_cell_known,
    output logic                        o_in_range,
    output logic [CNT_W-1:0]            o_known_count
);

    localparam int HXW = $clog2(MAX_HALF_X + 1);
    localparam int HYW = $clog2(MAX_HALF_Y + 1);
    localparam int HZW = $clog2(MAX_HALF_Z + 1);
    localparam int A1W = $clog2((2 * MAX_HALF_X + 1) * (2 * MAX_HALF_Y + 1));

    // Effective half extents and axis sizes
    logic [HXW-1:0] hx_eff;
    logic [HYW-1:0] hy_eff;
    logic [HZW-1:0] hz_eff;
    logic [HYW:0]   ny;
    logic [HZW:0]   nz;

    // Range check and first index step
    logic [COORD_W:0]     sum_x;
    logic [COORD_W:0]     sum_y;
    logic [COORD_W:0]     sum_z;
    logic                 in_x;
    logic                 in_y;
    logic                 in_z;
    logic [HXW+HYW+1:0]   prod_xy;
    logic [A1W-1:0]       a1_next;
    logic [A1W+HZW:0]     prod_a;
    logic [AW-1:0]        addr_next;

    // Log-odds decode
    logic [LOGODDS_W-1:0] a_abs;

    // Captured item
    t_command             r_cmd;
    logic [PROB_W-1:0]    r_set_prob;
    logic                 r_lo_pos;
    logic                 r_lo_neg;
    logic                 r_sig_use;
    logic                 r_inr;
    logic [A1W-1:0]       r_a1;
    logic [HZW:0]         r_oz;
    logic [AW-1:0]        r_addr;

    // Sigmoid unit
    logic [EN_W-1:0]      r_en;
    logic [EF_W-1:0]      r_ef;
    logic [EN_HALF-1:0]   mul_a;
    logic [PP_W-1:0]      mul_p;
    logic [PP_W-1:0]      r_plo;
    logic [PP_W-1:0]      r_phi;
    logic [PROD_W-1:0]    prod_full;
    logic [D_W-1:0]       r_d;
    logic [D_W-1:0]       r_rem;
    logic [DSH_W-1:0]     r_dsh;
    logic [Q_W-1:0]       r_q;
    logic [QCNT_W-1:0]    r_dcnt;
    logic                 div_ge;
    logic [PROB_W-1:0]    sig_s;
    logic [PROB_W-1:0]    load_prob;

    // Cell update
    logic                 old_known;
    logic [PROB_W-1:0]    new_prob;
    logic                 new_known;
    logic                 cell_wr;

    // Control registers
    logic [AW-1:0]        r_clr_addr;
    logic [CNT_W-1:0]     r_count;

    // Output register
    logic [PROB_W-1:0]    r_out_prob;
    logic                 r_out_known;
    logic                 r_out_inr;

    // Clamp the configured half extents to the grid capacity
    always_comb begin
        hx_eff = (int'(i_cfg.half_extent_x) > MAX_HALF_X) ? HXW'(MAX_HALF_X)
                                                          : HXW'(i_cfg.half_extent_x);
        hy_eff = (int'(i_cfg.half_extent_y) > MAX_HALF_Y) ? HYW'(MAX_HALF_Y)
                                                          : HYW'(i_cfg.half_extent_y);
        hz_eff = (int'(i_cfg.half_extent_z) > MAX_HALF_Z) ? HZW'(MAX_HALF_Z)
                                                          : HZW'(i_cfg.half_extent_z);
    end

    assign ny = {hy_eff, 1'b1};
    assign nz = {hz_eff, 1'b1};

    // Shift each coordinate by its half extent; inside means 0..2h
    assign sum_x = {i_coord_x[COORD_W-1], i_coord_x} + (COORD_W + 1)'(hx_eff);
    assign sum_y = {i_coord_y[COORD_W-1], i_coord_y} + (COORD_W + 1)'(hy_eff);
    assign sum_z = {i_coord_z[COORD_W-1], i_coord_z} + (COORD_W + 1)'(hz_eff);
    assign in_x  = !sum_x[COORD_W] && (sum_x <= (COORD_W + 1)'({hx_eff, 1'b0}));
    assign in_y  = !sum_y[COORD_W] && (sum_y <= (COORD_W + 1)'({hy_eff, 1'b0}));
    assign in_z  = !sum_z[COORD_W] && (sum_z <= (COORD_W + 1)'({hz_eff, 1'b0}));

    // Index: ((x + hx) * ny + (y + hy)) * nz + (z + hz), one product a cycle
    assign prod_xy   = sum_x[HXW:0] * ny;
    assign a1_next   = A1W'(prod_xy) + A1W'(sum_y[HYW:0]);
    assign prod_a    = r_a1 * nz;
    assign addr_next = AW'(prod_a) + AW'(r_oz);

    // Magnitude of the log-odds
    assign a_abs = i_log_odds[LOGODDS_W-1] ? LOGODDS_W'(-i_log_odds)
                                           : LOGODDS_W'(i_log_odds);

    // Capture the item on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd      <= t_command'(i_command);
            r_set_prob <= (i_prob_value > PROB_ONE) ? PROB_ONE : i_prob_value;
            r_lo_pos   <= !i_log_odds[LOGODDS_W-1] && (|i_log_odds);
            r_lo_neg   <= i_log_odds[LOGODDS_W-1];
            r_sig_use  <= a_abs < SIG_LIMIT;
            r_inr      <= in_x && in_y && in_z;
            r_a1       <= a1_next;
            r_oz       <= sum_z[HZW:0];
            r_en       <= EN_TABLE[a_abs[11:8]];
            r_ef       <= EF_TABLE[a_abs[7:0]];
        end
    end

    // Shared 18x22 multiplier for the two halves of e^n * e^(f/256)
    assign mul_a = i_cmd.mul_hi ? r_en[EN_W-1:EN_HALF] : r_en[EN_HALF-1:0];
    assign mul_p = mul_a * r_ef;
    assign prod_full = {r_phi, {EN_HALF{1'b0}}} + PROD_W'(r_plo) + PROD_ROUND;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_lo) begin
            r_plo <= mul_p;
        end
        if (i_cmd.mul_hi) begin
            r_phi <= mul_p;
        end
        if (i_cmd.sum) begin
            r_d <= prod_full[PROD_W-1:Q20_FRAC] + D_ONE;
        end
    end

    // Restoring divide, one quotient bit a cycle
    assign div_ge = {{(DSH_W - D_W){1'b0}}, r_rem} >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem  <= DIV_NUM + (r_d >> 1);
            r_dsh  <= DSH_W'(r_d) << (Q_W - 1);
            r_q    <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            if (div_ge) begin
                r_rem <= r_rem - D_W'(r_dsh);
            end
            r_dsh  <= r_dsh >> 1;
            r_q    <= {r_q[Q_W-2:0], div_ge};
            r_dcnt <= r_dcnt + 1'b1;
        end
    end

    // Loaded probability: binary or sigmoid
    assign sig_s = r_sig_use ? PROB_W'(r_q) : PROB_ZERO;

    always_comb begin
        if (i_cfg.binary_mode) begin
            load_prob = r_lo_pos ? PROB_ONE : PROB_ZERO;
        end else begin
            load_prob = r_lo_neg ? sig_s : PROB_ONE - sig_s;
        end
    end

    // Read address register for the write back
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_addr <= addr_next;
        end
    end

    // New cell contents per command
    assign old_known = i_ram_rdata[WORD_W-1];

    always_comb begin
        unique case (r_cmd)
            CMD_GET: begin
                new_prob  = i_ram_rdata[PROB_W-1:0];
                new_known = old_known;
            end
            CMD_SET: begin
                new_prob  = r_set_prob;
                new_known = 1'b1;
            end
            CMD_CLEAR: begin
                new_prob  = PROB_HALF;
                new_known = 1'b0;
            end
            CMD_LOAD: begin
                new_prob  = load_prob;
                new_known = 1'b1;
            end
            default: begin
                new_prob  = i_ram_rdata[PROB_W-1:0];
                new_known = old_known;
            end
        endcase
    end

    assign cell_wr = i_cmd.finish && r_inr && (r_cmd != CMD_GET);

    // RAM ports: clearing sweep or cell write back
    assign o_ram_we    = i_cmd.clr_en || cell_wr;
    assign o_ram_waddr = i_cmd.clr_en ? r_clr_addr : r_addr;
    assign o_ram_wdata = i_cmd.clr_en ? '0 : {new_known, new_prob};
    assign o_ram_re    = i_cmd.rd_en;
    assign o_ram_raddr = addr_next;

    // Clearing sweep address and known-cell count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_count    <= '0;
        end else begin
            if (i_cmd.clr_en) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (cell_wr && new_known && !old_known) begin
                r_count <= r_count + 1'b1;
            end else if (cell_wr && !new_known && old_known) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Output register, loaded when the item finishes
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_prob  <= r_inr ? new_prob : PROB_HALF;
            r_out_known <= r_inr && new_known;
            r_out_inr   <= r_inr;
        end
    end

    assign o_stat.clr_last = (r_clr_addr == AW'(DEPTH - 1));
    assign o_stat.sig_need = (t_command'(i_command) == CMD_LOAD)
                             && !i_cfg.binary_mode && (a_abs < SIG_LIMIT);
    assign o_stat.div_last = (r_dcnt == QCNT_W'(Q_W - 1));

    assign o_probability = r_out_prob;
    assign o_cell_known  = r_out_known;
    assign o_in_range    = r_out_inr;
    assign o_known_count = r_count;

    // Out-of-grid items leave the count alone
    a_count_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && !r_inr) |=> (r_count == $past(r_count)))
        else $error("count changed on an out-of-grid item");

    // Count never exceeds the number of cells
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("known count above grid size");

    // Division always starts from a fresh step count
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_cmd.div_step) |-> (r_dcnt == '0))
        else $error("divide started without init");

endmodule

// ===== sv/dense_3d_occupancy_grid_store_unit.sv =====
// ----------------------------------------------------------------------------
// dense_3d_occupancy_grid_store_unit
// Centered 3D voxel grid holding a probability and a known bit per cell,
// with get, set, clear and log-odds load commands and a known-cell count.
// ----------------------------------------------------------------------------
// After reset the block sweeps the cell RAM to zero, one cell a cycle, over
// all (2*MAX_HALF_X+1)*(2*MAX_HALF_Y+1)*(2*MAX_HALF_Z+1) cells (14415 at the
// defaults) and takes no item until the sweep ends; configuration writes are
// taken at any time. Each item is a read-modify-write of one cell through a
// single RAM: get, set, clear, binary loads and loads with |log-odds| of 12.0
// or more do the index multiply and read, then the write back, and the next
// item can be taken in the write-back step while the output register drains.
// A non-binary load with |log-odds| below 12.0 first runs two partial
// products on a shared 18x22 multiplier, a rounding sum and a 16-step
// restoring divide. One result item comes out per input item, in order.
// ----------------------------------------------------------------------------
module dense_3d_occupancy_grid_store_unit import ogs_pkg::*; #(
    parameter int MAX_HALF_X = DEF_MAX_HALF_X,
    parameter int MAX_HALF_Y = DEF_MAX_HALF_Y,
    parameter int MAX_HALF_Z = DEF_MAX_HALF_Z,
    localparam int DEPTH = (2 * MAX_HALF_X + 1) * (2 * MAX_HALF_Y + 1)
                         * (2 * MAX_HALF_Z + 1),
    localparam int AW    = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [CMD_W-1:0]            i_command,
    input  logic signed [COORD_W-1:0]   i_coord_x,
    input  logic signed [COORD_W-1:0]   i_coord_y,
    input  logic signed [COORD_W-1:0]   i_coord_z,
    input  logic [PROB_W-1:0]           i_prob_value,
    input  logic signed [LOGODDS_W-1:0] i_log_odds,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [PROB_W-1:0]           o_probability,
    output logic                        o_cell_known,
    output logic                        o_in_range,
    output logic [CNT_W-1:0]            o_known_count
);

    t_cfg              r_cfg;
    t_dp_cmd           dp_cmd;
    t_dp_stat          dp_stat;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_extent_x <= RST_HALF_X;
            r_cfg.half_extent_y <= RST_HALF_Y;
            r_cfg.half_extent_z <= RST_HALF_Z;
            r_cfg.binary_mode   <= RST_BINARY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HALF_X: r_cfg.half_extent_x <= i_cfg_data[3:0];
                CFG_HALF_Y: r_cfg.half_extent_y <= i_cfg_data[3:0];
                CFG_HALF_Z: r_cfg.half_extent_z <= i_cfg_data[2:0];
                CFG_BINARY: r_cfg.binary_mode   <= i_cfg_data[0];
            endcase
        end
    end

    ogs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    ogs_dp #(
        .MAX_HALF_X (MAX_HALF_X),
        .MAX_HALF_Y (MAX_HALF_Y),
        .MAX_HALF_Z (MAX_HALF_Z)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_command     (i_command),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_prob_value  (i_prob_value),
        .i_log_odds    (i_log_odds),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_re      (ram_re),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata),
        .o_probability (o_probability),
        .o_cell_known  (o_cell_known),
        .o_in_range    (o_in_range),
        .o_known_count (o_known_count)
    );

    // Cell store: {known, probability} per cell
    ogs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule
